// ===== design/mpms_pkg.sv =====
// Package for the motor position move simulator.
// Holds the fixed-point formats, the control constants and the input request type.
// No dependencies.
package mpms_pkg;

  // Fixed-point formats: position is signed Q32.16.
  localparam int unsigned FracBits = 16;
  localparam int unsigned CountW   = 32;
  localparam int unsigned PosW     = CountW + FracBits;
  localparam int unsigned ErrW     = PosW + 1;
  localparam int unsigned SpeedW   = 32;

  // Deadband of eight counts and a half-count speed, both in Q.16.
  localparam logic signed [ErrW-1:0]   DeadbandQ = ErrW'(8) <<< FracBits;
  localparam logic signed [SpeedW-1:0] HalfQ     = SpeedW'(1) <<< (FracBits - 1);

  // Position saturation limits.
  localparam logic signed [PosW-1:0] PosMax = {1'b0, {(PosW-1){1'b1}}};
  localparam logic signed [PosW-1:0] PosMin = {1'b1, {(PosW-1){1'b0}}};

  // One update request as held in the input register.
  typedef struct packed {
    logic [1:0]         motor_index;
    logic [14:0]        speed_limit;
    logic signed [31:0] target_position;
    logic signed [7:0]  drive_level;
    logic               clear_position;
    logic [15:0]        elapsed_time;
  } mpms_req_t;

endpackage

// ===== design/motor_position_move_simulator_top.sv =====
// Top level of the motor position move simulator: per-motor position update.
// Depends on mpms_pkg.
//
// Usage: every request on the input channel is one update tick for one motor.
// It carries the motor index, the speed limit (0 selects direct drive mode),
// the target count, the drive level, a clear flag and the elapsed time.
// Every request yields exactly one result: the motor index, the new integer
// count (truncated toward zero) and the mask of motors in a position move.
// A request to a motor index at or above MOTOR_COUNT changes nothing and
// returns count 0 with the current mask.
// Both channels use valid/stall; a request moves when valid is high and
// stall is low. The request is captured in an input register, the update is
// computed combinationally from it, and the result is registered: the result
// is offered from the result register. One request is taken per cycle while
// the receiver does not stall; the rate is set by the read-modify-write of
// the per-motor position register, so back-to-back ticks to the same motor
// see each other's updates. When the receiver stalls, the result holds and
// the input register keeps its request, after which the input channel stalls too.
// Reset clears all positions to zero, the motion mask and both valid flags.
module motor_position_move_simulator_top #(
  parameter int MOTOR_COUNT = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         motor_index_i,
  input  logic [14:0]        speed_limit_i,
  input  logic signed [31:0] target_position_i,
  input  logic signed [7:0]  drive_level_i,
  input  logic               clear_position_i,
  input  logic [15:0]        elapsed_time_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         motor_index_out_o,
  output logic signed [31:0] position_count_o,
  output logic [3:0]         moving_mask_o
);
  import mpms_pkg::*;

  localparam int MotorIdxW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int FlagW     = (MOTOR_COUNT > 4) ? MOTOR_COUNT : 4;

  // Truncate a Q32.16 position toward zero to its integer count.
  function automatic logic signed [CountW-1:0] trunc_count(input logic signed [PosW-1:0] p);
    logic signed [CountW-1:0] c;
    c = p[PosW-1:FracBits];
    if (p[PosW-1] && (p[FracBits-1:0] != '0)) begin
      c = c + CountW'(1);
    end
    return c;
  endfunction

  mpms_req_t                 req_q;
  logic                      in_vld_q;
  logic                      out_vld_q;
  logic                      adv;
  logic                      in_take;
  logic signed [PosW-1:0]    pos_q [MOTOR_COUNT];
  logic [FlagW-1:0]          flags_q, flags_d;
  logic [1:0]                out_idx_q;
  logic signed [CountW-1:0]  out_count_q;
  logic [3:0]                out_mask_q;

  logic                      in_range;
  logic [MotorIdxW-1:0]      idx;
  logic signed [PosW-1:0]    pos_old, pos_new, pos_sat;
  logic signed [ErrW-1:0]    err, tgt_q;
  logic signed [ErrW:0]      err2, lim;
  logic signed [SpeedW-1:0]  lim32, speed, speed_pos;
  logic signed [CountW-1:0]  count_old;
  logic signed [11:0]        pwm_x, pwm15;
  logic                      in_dead, in_lin;
  logic                      spd_neg;
  logic [SpeedW-1:0]         spd_mag;
  logic [46:0]               prod;
  logic signed [ErrW-1:0]    step, sum;

  // Handshake: the compute stage advances when the result register is free.
  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q.motor_index     <= motor_index_i;
      req_q.speed_limit     <= speed_limit_i;
      req_q.target_position <= target_position_i;
      req_q.drive_level     <= drive_level_i;
      req_q.clear_position  <= clear_position_i;
      req_q.elapsed_time    <= elapsed_time_i;
    end
  end

  // Select the motor and read its current position.
  always_comb begin
    in_range = int'(req_q.motor_index) < MOTOR_COUNT;
    idx      = MotorIdxW'(req_q.motor_index);
    pos_old  = in_range ? pos_q[idx] : '0;
  end

  // Speed selection: proportional move with deadband, or direct drive.
  always_comb begin
    tgt_q     = {req_q.target_position[31], req_q.target_position, {FracBits{1'b0}}};
    err       = tgt_q - {pos_old[PosW-1], pos_old};
    err2      = {err, 1'b0};
    lim       = {{(ErrW + 1 - 15 - FracBits){1'b0}}, req_q.speed_limit, {FracBits{1'b0}}};
    lim32     = {1'b0, req_q.speed_limit, {FracBits{1'b0}}};
    count_old = trunc_count(pos_old);
    in_dead   = (err < DeadbandQ) && (err > -DeadbandQ);
    in_lin    = (err2 < lim) && (err2 > -lim);
    pwm_x     = {{4{req_q.drive_level[7]}}, req_q.drive_level};
    pwm15     = (pwm_x <<< 4) - pwm_x;
    flags_d   = flags_q;

    if (in_dead) begin
      speed_pos = '0;
    end else if (in_lin) begin
      speed_pos = err2[SpeedW-1:0];
    end else if (err[ErrW-1]) begin
      speed_pos = -lim32;
    end else begin
      speed_pos = lim32;
    end

    if (req_q.speed_limit != '0) begin
      speed = speed_pos;
      // Stop once the count has passed the target in the direction of travel.
      if (!speed_pos[SpeedW-1] && (speed_pos != '0) &&
          (count_old > req_q.target_position)) begin
        speed = '0;
        flags_d[req_q.motor_index] = 1'b0;
      end else if (speed_pos[SpeedW-1] && (count_old < req_q.target_position)) begin
        speed = '0;
        flags_d[req_q.motor_index] = 1'b0;
      end else if ((speed_pos > -HalfQ) && (speed_pos < HalfQ)) begin
        flags_d[req_q.motor_index] = 1'b0;
      end else begin
        flags_d[req_q.motor_index] = 1'b1;
      end
    end else begin
      speed = {{(SpeedW - 12 - FracBits){pwm15[11]}}, pwm15, {FracBits{1'b0}}};
    end

    if (!in_range) begin
      flags_d = flags_q;
    end
  end

  // Integrate speed times elapsed time, truncated toward zero, with saturation; a clear request zeroes the position.
  always_comb begin
    spd_neg = speed[SpeedW-1];
    spd_mag = spd_neg ? -speed : speed;
    prod    = spd_mag[30:0] * req_q.elapsed_time;
    step    = {{(ErrW - 31){1'b0}}, prod[46:FracBits]};
    if (spd_neg) begin
      step = -step;
    end
    sum = {pos_old[PosW-1], pos_old} + step;
    if (sum[ErrW-1] != sum[ErrW-2]) begin
      pos_sat = sum[ErrW-1] ? PosMin : PosMax;
    end else begin
      pos_sat = sum[PosW-1:0];
    end
    pos_new = req_q.clear_position ? '0 : pos_sat;
  end

  // Motor state, written when the update advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        pos_q[i] <= '0;
      end
      flags_q <= '0;
    end else if (adv) begin
      if (in_range) begin
        pos_q[idx] <= pos_new;
      end
      flags_q <= flags_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_idx_q   <= req_q.motor_index;
      out_count_q <= in_range ? trunc_count(pos_new) : '0;
      out_mask_q  <= flags_d[3:0];
    end
  end

  assign out_valid_o       = out_vld_q;
  assign motor_index_out_o = out_idx_q;
  assign position_count_o  = out_count_q;
  assign moving_mask_o     = out_mask_q;

`ifndef SYNTHESIS
  // The input side only stalls while it holds a request.
  a_stall_holds_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q)
    else $error("input stall without a held request");

  // A held request that cannot advance is kept.
  a_req_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !adv) |=> in_vld_q)
    else $error("held request lost");

  // Every advanced update shows up as a result.
  a_adv_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("advanced update produced no result");

  // A clear request on a valid motor reports count zero.
  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_range && req_q.clear_position) |=> (out_count_q == '0))
    else $error("cleared motor reported nonzero count");
`endif

endmodule
